### rtl/bbea_pkg.sv
// Package for the edge-aware 3x3 box blur: constants, types and the reciprocal table.
`timescale 1ns / 1ps

package bbea_pkg;

    // Frame limits and derived widths
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int DIM_W       = 11;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 12;
    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int CNT_W       = 4;
    localparam int APB_ADDR_W  = 3;

    localparam logic [DIM_W-1:0] MAX_WIDTH_DIM  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_DIM = DIM_W'(MAX_HEIGHT);

    // Register select, taken from paddr bit 2
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Word kinds on the input stream
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // One RGB pixel; red sits in the lowest byte
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    // One line store entry: the two rows above the current input row
    typedef struct packed {
        pixel_t older;
        pixel_t newer;
    } line_entry_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SHIFT = 5'b00010,
        ST_SUM   = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // Reciprocal ceil(2^RECIP_SHIFT / (2*n)); exact for numerators below 2^NUM_W
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        begin
            case (n)
                4'd2:    r = RECIP_W'(65536);
                4'd3:    r = RECIP_W'(43691);
                4'd4:    r = RECIP_W'(32768);
                4'd6:    r = RECIP_W'(21846);
                4'd9:    r = RECIP_W'(14564);
                default: r = RECIP_W'(131072);
            endcase
            return r;
        end
    endfunction

    // A dimension of zero acts as one, anything above the limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > lim)
            begin
                r = lim;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

### rtl/box_blur_3x3_edge_aware.sv
// Edge-aware 3x3 box blur over an RGB raster stream, with a shared line store.
// An ignored drain word is dropped in idle; a word that yields no result passes shift only;
// a word that yields a result passes shift, sum, multiply and output, and waits in output
// while the output register stays full behind a stalled receiver. Input is ready only in idle.
// One sequencer does the line store read, window sum, multiply and output load in turn.
// Reset (asynchronous, active low) clears sequencer, positions, window and sizes (1 x 1).
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bbea_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // in_red, in_green, in_blue
    input  logic                             s_axis_tuser,  // kind
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // out_red, out_green, out_blue
    output logic                             m_axis_tlast   // frame_end
);
    import bbea_pkg::*;

    // Registers
    state_t                 state_reg,     state_next;
    logic [DIM_W-1:0]       width_reg,     width_next;
    logic [DIM_W-1:0]       height_reg,    height_next;
    logic [COL_W-1:0]       in_col_reg,    in_col_next;
    logic [DIM_W-1:0]       in_row_reg,    in_row_next;
    logic [COL_W-1:0]       out_col_reg,   out_col_next;
    logic [DIM_W-1:0]       out_row_reg,   out_row_next;
    pixel_t                 win_reg [3][3];
    pixel_t                 win_next [3][3];
    pixel_t                 pix_reg,       pix_next;
    logic                   emit_reg,      emit_next;
    logic [2:0]             col_ok_reg,    col_ok_next;
    logic [2:0]             row_ok_reg,    row_ok_next;
    logic                   last_reg,      last_next;
    logic [SUM_W-1:0]       sum_reg [3];
    logic [SUM_W-1:0]       sum_next [3];
    logic [CNT_W-1:0]       cnt_reg,       cnt_next;
    logic [PROD_W-1:0]      prod_reg [3];
    logic [PROD_W-1:0]      prod_next [3];
    logic                   m_valid_reg,   m_valid_next;
    logic                   m_last_reg,    m_last_next;
    pixel_t                 m_data_reg,    m_data_next;
    line_entry_t            rd_data_reg;

    // Line store
    line_entry_t            line_mem [MAX_WIDTH];

    logic                   cfg_wr;
    logic                   in_acc;
    logic                   pixels_done;
    logic                   drain_skip;
    logic                   mem_rd;
    logic                   mem_wr;
    line_entry_t            mem_wdata;
    logic [DIM_W-1:0]       in_col_inc;
    logic [DIM_W-1:0]       out_col_inc;
    logic [DIM_W-1:0]       out_row_adv;
    logic [COL_W-1:0]       out_col_adv;
    logic [SUM_W-1:0]       col_sum [3][3];
    logic [SUM_W-1:0]       tot_sum [3];
    logic [1:0]             n_cols;
    logic [1:0]             n_rows;
    logic [CNT_W-1:0]       n_all;
    logic [NUM_W-1:0]       numer [3];
    logic [RECIP_W-1:0]     recip;
    logic [CHAN_W-1:0]      quot [3];

    // Handshake and configuration decode
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pixels_done   = (in_row_reg >= height_reg);
    assign drain_skip    = (s_axis_tuser == KIND_DRAIN) && !pixels_done;
    assign mem_rd        = in_acc && !drain_skip;
    assign mem_wr        = (state_reg == ST_SHIFT);
    assign mem_wdata     = '{older: rd_data_reg.newer, newer: pix_reg};

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // Register read-back
    always_comb
    begin
        if (paddr[2] == REG_HEIGHT)
        begin
            prdata = {{(32-DIM_W){1'b0}}, height_reg};
        end
        else
        begin
            prdata = {{(32-DIM_W){1'b0}}, width_reg};
        end
    end

    // Line store: read on acceptance, write back the shifted column in the next cycle
    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_data_reg <= line_mem[in_col_reg];
        end
        if (mem_wr)
        begin
            line_mem[in_col_reg] <= mem_wdata;
        end
    end

    // Masked window sums, column by column and then across columns
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                col_sum[k][ch] = '0;
            end
            for (int j = 0; j < 3; j++)
            begin
                if (col_ok_reg[k] && row_ok_reg[j])
                begin
                    col_sum[k][0] = col_sum[k][0] + SUM_W'(win_reg[k][j].red);
                    col_sum[k][1] = col_sum[k][1] + SUM_W'(win_reg[k][j].green);
                    col_sum[k][2] = col_sum[k][2] + SUM_W'(win_reg[k][j].blue);
                end
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            tot_sum[ch] = col_sum[0][ch] + col_sum[1][ch] + col_sum[2][ch];
        end
        n_cols = 2'(col_ok_reg[0]) + 2'(col_ok_reg[1]) + 2'(col_ok_reg[2]);
        n_rows = 2'(row_ok_reg[0]) + 2'(row_ok_reg[1]) + 2'(row_ok_reg[2]);
        n_all  = CNT_W'(n_cols) * CNT_W'(n_rows);
    end

    // Rounded mean as (2*sum + n) times the reciprocal of 2*n
    always_comb
    begin
        recip = recip_of(cnt_reg);
        for (int ch = 0; ch < 3; ch++)
        begin
            numer[ch] = {sum_reg[ch], 1'b0} + NUM_W'(cnt_reg);
            quot[ch]  = prod_reg[ch][RECIP_SHIFT +: CHAN_W];
        end
    end

    // Position arithmetic
    assign in_col_inc  = DIM_W'(in_col_reg) + DIM_W'(1);
    assign out_col_inc = DIM_W'(out_col_reg) + DIM_W'(1);

    always_comb
    begin
        if (out_col_inc >= width_reg)
        begin
            out_col_adv = '0;
            out_row_adv = out_row_reg + DIM_W'(1);
        end
        else
        begin
            out_col_adv = out_col_inc[COL_W-1:0];
            out_row_adv = out_row_reg;
        end
    end

    // Sequencer and datapath next values
    always_comb
    begin
        state_next   = state_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        win_next     = win_reg;
        pix_next     = pix_reg;
        emit_next    = emit_reg;
        col_ok_next  = col_ok_reg;
        row_ok_next  = row_ok_reg;
        last_next    = last_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg;

        // The output register empties as soon as its word is taken
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // A drain word before the frame is complete is dropped
                if (in_acc && !drain_skip)
                begin
                    pix_next  = pixels_done ? pixel_t'('0) : pixel_t'(s_axis_tdata);
                    emit_next = (in_row_reg > DIM_W'(1)) ||
                                ((in_row_reg == DIM_W'(1)) && (in_col_reg != '0));
                    col_ok_next = {out_col_inc < width_reg, 1'b1, out_col_reg != '0};
                    row_ok_next = {(out_row_reg + DIM_W'(1)) < height_reg,
                                   out_row_reg < height_reg,
                                   out_row_reg != '0};
                    state_next  = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // Shift the window one column and load the new column
                for (int j = 0; j < 3; j++)
                begin
                    win_next[0][j] = win_reg[1][j];
                    win_next[1][j] = win_reg[2][j];
                end
                win_next[2][0] = rd_data_reg.older;
                win_next[2][1] = rd_data_reg.newer;
                win_next[2][2] = pix_reg;

                if (in_col_inc >= width_reg)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + DIM_W'(1);
                end
                else
                begin
                    in_col_next = in_col_inc[COL_W-1:0];
                end

                if (emit_reg)
                begin
                    out_col_next = out_col_adv;
                    out_row_next = out_row_adv;
                    last_next    = (out_row_adv >= height_reg);
                    // The frame is complete: every position returns to the start
                    if (out_row_adv >= height_reg)
                    begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                    end
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                sum_next   = tot_sum;
                cnt_next   = (n_all == '0) ? CNT_W'(1) : n_all;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    prod_next[ch] = PROD_W'(numer[ch]) * PROD_W'(recip);
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Load the result once the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next  = '{blue: quot[2], green: quot[1], red: quot[0]};
                    m_last_next  = last_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write restarts the frame
        if (cfg_wr)
        begin
            if (paddr[2] == REG_HEIGHT)
            begin
                height_next = clamp_dim(pwdata[DIM_W-1:0], MAX_HEIGHT_DIM);
            end
            else
            begin
                width_next = clamp_dim(pwdata[DIM_W-1:0], MAX_WIDTH_DIM);
            end
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            width_reg   <= DIM_W'(1);
            height_reg  <= DIM_W'(1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else
        begin
            state_reg   <= state_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            m_valid_reg <= m_valid_next;
            win_reg     <= win_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pix_reg    <= pix_next;
        emit_reg   <= emit_next;
        col_ok_reg <= col_ok_next;
        row_ok_reg <= row_ok_next;
        last_reg   <= last_next;
        sum_reg    <= sum_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

endmodule
